FILE: sv/bouncing_particle_step_assert.svh
// Assertion macros for the bouncing particle step checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BOUNCING_PARTICLE_STEP_ASSERT_SVH
`define BOUNCING_PARTICLE_STEP_ASSERT_SVH

// same-cycle implication
`define BPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bps_pkg.sv
// Shared widths, register indexes, reset values and types for the
// bouncing particle step block. No dependencies.
package bps_pkg;

  localparam int unsigned VW       = 24;  // Q16.8 position / velocity
  localparam int unsigned DTW      = 24;  // Q4.20 step time
  localparam int unsigned DT_FRAC  = 20;
  localparam int unsigned ABW      = 16;  // Q1.15 absorption
  localparam int unsigned ABS_FRAC = 15;
  localparam int unsigned DIMW     = 15;
  localparam int unsigned RADW     = 14;
  localparam int unsigned PIX_FRAC = 8;
  localparam int unsigned HITS_W   = 4;

  localparam int unsigned CNT_W  = $clog2(DTW);
  localparam int unsigned PDT_W  = VW + 1 + DTW - DT_FRAC;
  localparam int unsigned PABS_W = VW + 1 + ABW + ABS_FRAC - ABW - ABW + 1;
  localparam int unsigned ABS_LO = DTW - ABW + ABS_FRAC;

  localparam int unsigned IN_TDATA_W  = ((DTW + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((4 * VW + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = HITS_W + 1;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY,
    REG_ABSORPTION,
    REG_AREA_WIDTH,
    REG_AREA_HEIGHT,
    REG_RADIUS,
    REG_START_VX,
    REG_START_VY
  } bps_reg_e;

  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  localparam logic [VW-1:0]   GRAVITY_RST    = VW'(256000);
  localparam logic [ABW-1:0]  ABSORPTION_RST = ABW'(26214);
  localparam logic [DIMW-1:0] AREA_W_RST     = DIMW'(1024);
  localparam logic [DIMW-1:0] AREA_H_RST     = DIMW'(768);
  localparam logic [RADW-1:0] RADIUS_RST     = RADW'(100);
  localparam logic [VW-1:0]   START_VX_RST   = VW'(128000);
  localparam logic [VW-1:0]   START_VY_RST   = VW'(-384000);

  localparam logic [VW-1:0] POS_X_RST = VW'({AREA_W_RST, {(PIX_FRAC-1){1'b0}}});
  localparam logic [VW-1:0] POS_Y_RST = VW'({AREA_H_RST, {(PIX_FRAC-1){1'b0}}});

  typedef struct packed {
    logic start;
    logic short_op;  // 16-bit multiplier (absorption) instead of 24-bit
  } bps_mul_req_t;

endpackage

FILE: sv/bps_ser_mul.sv
// Bit-serial signed x unsigned multiplier, one multiplier bit per cycle,
// with rounded Q16.8 results for step time and absorption. Uses bps_pkg.
module bps_ser_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bps_pkg::bps_mul_req_t                req_i,
  input  logic signed [bps_pkg::VW-1:0]        mcand_i,
  input  logic        [bps_pkg::DTW-1:0]       mplier_i,
  output logic                                 done_o,
  output logic signed [bps_pkg::PDT_W-1:0]     prod_dt_o,
  output logic signed [bps_pkg::PABS_W-1:0]    prod_abs_o
);
  import bps_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic signed [VW-1:0] mcand_q;
  logic signed [VW:0]   hi_q;
  logic [DTW-1:0]       lo_q;
  logic [VW+1:0]        sum;

  assign sum = {hi_q[VW], hi_q} + (lo_q[0] ? {{2{mcand_q[VW-1]}}, mcand_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.short_op ? CNT_W'(ABW - 1) : CNT_W'(DTW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplier_i;
    end else if (busy_q) begin
      hi_q <= sum[VW+1:1];
      lo_q <= {sum[0], lo_q[DTW-1:1]};
    end
  end

  // round half up: drop fraction, add the first dropped bit
  assign prod_dt_o  = PDT_W'($signed({hi_q, lo_q[DTW-1:DT_FRAC]})
                             + $signed({1'b0, lo_q[DT_FRAC-1]}));
  assign prod_abs_o = PABS_W'($signed({hi_q, lo_q[DTW-1:ABS_LO]})
                              + $signed({1'b0, lo_q[ABS_LO-1]}));
  assign done_o     = done_q;

endmodule

FILE: sv/bouncing_particle_step.sv
// A restart item goes straight to the output stage; a step item moves x, moves y, adds gravity,
// then tests each wall in turn. Each product goes through one bit-serial multiplier: step_time for
// moves, step-backs and gravity, absorption when a wall is crossed; a velocity negation needs no multiply.
// One item at a time; a new item is taken while the result waits.
// Reset: asynchronous, active low; registers to defaults, particle centred, output empty.
module bouncing_particle_step (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bps_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // step_time
  input  logic [0:0]                          s_axis_tuser,   // restart
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bps_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // pos_x, pos_y, vel_x, vel_y
  output logic [bps_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,   // wall_hits, saturated
  input  logic                                cfg_we_i,
  input  logic [bps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bps_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import bps_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_CHECK, S_DONE} state_e;
  typedef enum logic [1:0] {PH_MOVE_X, PH_MOVE_Y, PH_GRAV, PH_WALL} phase_e;
  typedef enum logic [1:0] {W_TOP, W_BOTTOM, W_LEFT, W_RIGHT} wall_e;
  typedef enum logic [1:0] {HS_BACK, HS_ABS_AXIS, HS_ABS_OTHER, HS_NEG} hit_step_e;
  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_ABS, OP_NEG} op_e;
  typedef enum logic [1:0] {DST_PX, DST_PY, DST_VX, DST_VY} dst_e;

  localparam int unsigned TW   = PDT_W + 1;
  localparam int unsigned CHKW = VW + 2;
  localparam logic signed [TW-1:0] T_MAX = {{(TW-VW){1'b0}}, VAL_MAX};
  localparam logic signed [TW-1:0] T_MIN = {{(TW-VW){1'b1}}, VAL_MIN};

  // configuration
  logic [VW-1:0]   grav_q;
  logic [ABW-1:0]  absorb_q;
  logic [DIMW-1:0] area_w_q;
  logic [DIMW-1:0] area_h_q;
  logic [RADW-1:0] radius_q;
  logic [VW-1:0]   start_vx_q;
  logic [VW-1:0]   start_vy_q;

  state_e               state_q;
  phase_e               phase_q;
  wall_e                wall_q;
  hit_step_e            sub_q;
  logic [DTW-1:0]       dt_q;
  logic [HITS_W-1:0]    hits_q;
  logic                 sat_q;
  logic signed [VW-1:0] px_q, py_q, vx_q, vy_q;
  logic                 m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic [OUT_TUSER_W-1:0] m_user_q;

  op_e                  op;
  dst_e                 dst;
  logic signed [VW-1:0] mcand;
  logic signed [VW-1:0] dst_val;
  logic signed [TW-1:0] d_ext, t;
  logic signed [VW-1:0] res;
  logic                 clip;
  logic                 apply;
  logic                 axis_x;
  logic                 hit;
  logic signed [CHKW-1:0] pos_c, rad_c, lim_c;
  logic                 s_acc;

  bps_mul_req_t              mul_req;
  logic                      mul_done;
  logic signed [PDT_W-1:0]   prod_dt;
  logic signed [PABS_W-1:0]  prod_abs;

  bps_ser_mul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mul_req),
    .mcand_i    (mcand),
    .mplier_i   ((op == OP_ABS) ? DTW'(absorb_q) : dt_q),
    .done_o     (mul_done),
    .prod_dt_o  (prod_dt),
    .prod_abs_o (prod_abs)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q     <= GRAVITY_RST;
      absorb_q   <= ABSORPTION_RST;
      area_w_q   <= AREA_W_RST;
      area_h_q   <= AREA_H_RST;
      radius_q   <= RADIUS_RST;
      start_vx_q <= START_VX_RST;
      start_vy_q <= START_VY_RST;
    end else if (cfg_we_i) begin
      unique case (bps_reg_e'(cfg_idx_i))
        REG_GRAVITY:     grav_q     <= cfg_data_i[VW-1:0];
        REG_ABSORPTION:  absorb_q   <= cfg_data_i[ABW-1:0];
        REG_AREA_WIDTH:  area_w_q   <= cfg_data_i[DIMW-1:0];
        REG_AREA_HEIGHT: area_h_q   <= cfg_data_i[DIMW-1:0];
        REG_RADIUS:      radius_q   <= cfg_data_i[RADW-1:0];
        REG_START_VX:    start_vx_q <= cfg_data_i[VW-1:0];
        REG_START_VY:    start_vy_q <= cfg_data_i[VW-1:0];
        default: ;
      endcase
    end
  end

  // operation decode
  assign axis_x = wall_q[1];

  always_comb begin
    op    = OP_ADD;
    dst   = DST_PX;
    mcand = vx_q;
    unique case (phase_q)
      PH_MOVE_X: begin
        dst   = DST_PX;
        mcand = vx_q;
      end
      PH_MOVE_Y: begin
        dst   = DST_PY;
        mcand = vy_q;
      end
      PH_GRAV: begin
        dst   = DST_VY;
        mcand = $signed(grav_q);
      end
      PH_WALL: begin
        unique case (sub_q)
          HS_BACK: begin
            op    = OP_SUB;
            dst   = axis_x ? DST_PX : DST_PY;
            mcand = axis_x ? vx_q : vy_q;
          end
          HS_ABS_AXIS: begin
            op    = OP_ABS;
            dst   = axis_x ? DST_VX : DST_VY;
            mcand = axis_x ? vx_q : vy_q;
          end
          HS_ABS_OTHER: begin
            op    = OP_ABS;
            dst   = axis_x ? DST_VY : DST_VX;
            mcand = axis_x ? vy_q : vx_q;
          end
          HS_NEG: begin
            op    = OP_NEG;
            dst   = axis_x ? DST_VX : DST_VY;
            mcand = axis_x ? vx_q : vy_q;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // saturating combine
  always_comb begin
    unique case (dst)
      DST_PX:  dst_val = px_q;
      DST_PY:  dst_val = py_q;
      DST_VX:  dst_val = vx_q;
      DST_VY:  dst_val = vy_q;
      default: dst_val = px_q;
    endcase
    d_ext = {{(TW-VW){dst_val[VW-1]}}, dst_val};
    unique case (op)
      OP_ADD:  t = d_ext + {prod_dt[PDT_W-1], prod_dt};
      OP_SUB:  t = d_ext - {prod_dt[PDT_W-1], prod_dt};
      OP_ABS:  t = {{(TW-PABS_W){prod_abs[PABS_W-1]}}, prod_abs};
      OP_NEG:  t = -d_ext;
      default: t = d_ext;
    endcase
    clip = 1'b0;
    res  = t[VW-1:0];
    if (t > T_MAX) begin
      clip = 1'b1;
      res  = VAL_MAX;
    end else if (t < T_MIN) begin
      clip = 1'b1;
      res  = VAL_MIN;
    end
  end

  // wall test, exact
  always_comb begin
    pos_c = axis_x ? {{2{px_q[VW-1]}}, px_q} : {{2{py_q[VW-1]}}, py_q};
    rad_c = CHKW'({radius_q, {PIX_FRAC{1'b0}}});
    lim_c = axis_x ? CHKW'({area_w_q, {PIX_FRAC{1'b0}}})
                   : CHKW'({area_h_q, {PIX_FRAC{1'b0}}});
    hit   = wall_q[0] ? ((pos_c + rad_c) > lim_c) : (pos_c < rad_c);
  end

  assign apply = ((state_q == S_MUL) && mul_done) || ((state_q == S_LOAD) && (op == OP_NEG));
  assign mul_req.start    = (state_q == S_LOAD) && (op != OP_NEG);
  assign mul_req.short_op = (op == OP_ABS);
  assign s_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_MOVE_X;
      wall_q    <= W_TOP;
      sub_q     <= HS_BACK;
      dt_q      <= '0;
      hits_q    <= '0;
      sat_q     <= 1'b0;
      px_q      <= POS_X_RST;
      py_q      <= POS_Y_RST;
      vx_q      <= START_VX_RST;
      vy_q      <= START_VY_RST;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
    end else begin
      if (m_axis_tready && (state_q != S_DONE)) begin
        m_valid_q <= 1'b0;
      end
      if (apply) begin
        unique case (dst)
          DST_PX:  px_q <= res;
          DST_PY:  py_q <= res;
          DST_VX:  vx_q <= res;
          DST_VY:  vy_q <= res;
          default: ;
        endcase
        sat_q <= sat_q | clip;
        unique case (phase_q)
          PH_MOVE_X: begin
            phase_q <= PH_MOVE_Y;
            state_q <= S_LOAD;
          end
          PH_MOVE_Y: begin
            phase_q <= PH_GRAV;
            state_q <= S_LOAD;
          end
          PH_GRAV: begin
            phase_q <= PH_WALL;
            wall_q  <= W_TOP;
            state_q <= S_CHECK;
          end
          PH_WALL: begin
            if (sub_q == HS_NEG) begin
              if (wall_q == W_RIGHT) begin
                state_q <= S_DONE;
              end else begin
                wall_q  <= wall_e'(wall_q + 1'b1);
                state_q <= S_CHECK;
              end
            end else begin
              sub_q   <= hit_step_e'(sub_q + 1'b1);
              state_q <= S_LOAD;
            end
          end
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            hits_q <= '0;
            sat_q  <= 1'b0;
            if (s_axis_tuser[0]) begin
              px_q    <= VW'({area_w_q, {(PIX_FRAC-1){1'b0}}});
              py_q    <= VW'({area_h_q, {(PIX_FRAC-1){1'b0}}});
              vx_q    <= start_vx_q;
              vy_q    <= start_vy_q;
              state_q <= S_DONE;
            end else begin
              dt_q    <= s_axis_tdata[DTW-1:0];
              phase_q <= PH_MOVE_X;
              state_q <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          if (op != OP_NEG) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: ;
        S_CHECK: begin
          if (hit) begin
            hits_q[wall_q] <= 1'b1;
            sub_q          <= HS_BACK;
            state_q        <= S_LOAD;
          end else if (wall_q == W_RIGHT) begin
            state_q <= S_DONE;
          end else begin
            wall_q <= wall_e'(wall_q + 1'b1);
          end
        end
        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= {vy_q, vx_q, py_q, px_q};
            m_user_q  <= {sat_q, hits_q};
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

FILE: sv/bps_checker.sv
// Port-level checks for bouncing_particle_step, bound to the top level.
// Uses bps_pkg and the macros in bouncing_particle_step_assert.svh.
`include "bouncing_particle_step_assert.svh"

module bps_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [0:0]                          s_axis_tuser,   // restart
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [bps_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // pos_x, pos_y, vel_x, vel_y
  input logic [bps_pkg::OUT_TUSER_W-1:0]     m_axis_tuser    // wall_hits, saturated
);
  import bps_pkg::*;

  logic s_acc;
  logic rst_acc;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign rst_acc = s_acc && s_axis_tuser[0] && !m_axis_tvalid;

  // output item holds while stalled
  `BPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
                   "result item changed while stalled")

  // one item in flight: input closes after acceptance
  `BPS_ASSERT_NEXT(a_busy_after_accept, s_acc, !s_axis_tready,
                   "input ready right after an accepted item")

  // a new result only comes out of a busy cycle
  `BPS_ASSERT_SAME(a_result_from_busy, $rose(m_axis_tvalid), $past(!s_axis_tready),
                   "result appeared without the block being busy")

  // restart item taken while the output is empty: clean result via S_DONE and the output register
  `BPS_ASSERT_SAME(a_restart_clean,
                   $past(rst_acc, 2) && $past(rst_ni, 2) && $past(rst_ni, 1),
                   m_axis_tvalid && (m_axis_tuser == '0),
                   "restart result missing or flagged")

endmodule

bind bouncing_particle_step bps_checker u_bps_checker (.*);
